// File: rtl/aff2d_pkg.sv
// ----------------------------------------------------------------------------
// aff2d_pkg
// Shared types and constants of the 2D affine point transform unit.
// ----------------------------------------------------------------------------
package aff2d_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int COORD_BITS    = 16;
    localparam int OUT_BITS      = 48;
    localparam int REG_COUNT     = 6;
    localparam int ADDR_BITS     = 5;
    localparam int DATA_BITS     = 32;
    localparam int CORDIC_STEPS  = 16;
    localparam int ITER_BITS     = 4;

    localparam logic [29:0] CORDIC_GAIN = 30'd652032874;

    localparam logic [22:0] ATAN_DEG_Q16 [CORDIC_STEPS] = '{
        23'd2949120, 23'd1740967, 23'd919879, 23'd466945,
        23'd234379,  23'd117304,  23'd58666,  23'd29335,
        23'd14668,   23'd7334,    23'd3667,   23'd1833,
        23'd917,     23'd458,     23'd229,    23'd115
    };

    localparam logic [2:0] REG_MODE    = 3'd0;
    localparam logic [2:0] REG_PARAM_A = 3'd1;
    localparam logic [2:0] REG_PARAM_B = 3'd2;
    localparam logic [2:0] REG_PARAM_C = 3'd3;
    localparam logic [2:0] REG_PARAM_D = 3'd4;
    localparam logic [2:0] REG_ANGLE   = 3'd5;

    localparam logic [2:0] MODE_TRANSLATE = 3'd0;
    localparam logic [2:0] MODE_SCALE     = 3'd1;
    localparam logic [2:0] MODE_ROTATE    = 3'd2;
    localparam logic [2:0] MODE_SHEAR     = 3'd3;
    localparam logic [2:0] MODE_PIVOT     = 3'd4;
    localparam logic [2:0] MODE_REFLECT   = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_TRIG_FIN,
        ST_SQUARE,
        ST_NORM,
        ST_DIVIDE,
        ST_OFF_MUL,
        ST_OFF_SUM
    } setup_state_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x_in;
        logic signed [COORD_BITS-1:0] y_in;
    } in_beat_t;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] x_out;
        logic signed [OUT_BITS-1:0] y_out;
    } out_beat_t;

endpackage

// File: rtl/aff2d_setup.sv
// ----------------------------------------------------------------------------
// aff2d_setup
// Register file and coefficient builder: CORDIC sine and cosine, restoring
// division for the reflection matrix, and the offset multiply-add.
// ----------------------------------------------------------------------------
module aff2d_setup
    import aff2d_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int CW        = FRAC_BITS + 16,
    parameter int OW        = FRAC_BITS + 18
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ADDR_BITS-1:0]        paddr,
    input  logic [DATA_BITS-1:0]        pwdata,
    output logic [DATA_BITS-1:0]        prdata,
    output logic                        busy,
    output logic signed [CW-1:0]        coeff [4],
    output logic signed [OW-1:0]        offset [2]
);

    localparam int TW        = FRAC_BITS + 2;
    localparam int PW        = TW + 24;
    localparam int ZW        = 26;
    localparam int XW        = 34;
    localparam int RW        = 51;
    localparam int DIV_STEPS = FRAC_BITS + 2;
    localparam int DCW       = $clog2(DIV_STEPS);

    setup_state_t state_reg, state_next;

    logic [2:0]               mode_reg;
    logic signed [23:0]       pa_reg, pb_reg, pc_reg, pd_reg;
    logic signed [17:0]       angle_reg;
    logic                     start_reg;

    logic signed [ZW-1:0]     z_reg;
    logic signed [XW-1:0]     cx_reg, cy_reg;
    logic                     flip_reg;
    logic [ITER_BITS-1:0]     iter_reg;
    logic [23:0]              ux_reg, uy_reg;
    logic                     neg1_reg, neg2_reg;
    logic [47:0]              ux2_reg, uy2_reg, uxy_reg;
    logic [49:0]              n_reg;
    logic [RW-1:0]            rem_reg;
    logic [TW-1:0]            quo_reg;
    logic [DCW-1:0]           dcnt_reg;
    logic                     phase_reg;
    logic signed [PW-1:0]     prod_reg [4];
    logic signed [CW-1:0]     coeff_reg [4];
    logic signed [OW-1:0]     off_reg [2];

    logic                     wr_en;
    logic [2:0]               idx;
    logic signed [CW-1:0]     a_full, b_full, one_c;
    logic signed [CW-1:0]     coeff_init [4];
    logic signed [OW-1:0]     off_init [2];
    logic signed [18:0]       z8_0, z8_1, z8_2;
    logic                     flip_d;
    logic signed [ZW-1:0]     z16;
    logic signed [24:0]       dx, dy;
    logic [24:0]              adx, ady;
    logic signed [XW-1:0]     shx, shy, xr, yr, xc, yc, one_x;
    logic signed [ZW-1:0]     atan_s;
    logic                     cordic_last;
    logic signed [TW-1:0]     c_val, s_val;
    logic [49:0]              nsum;
    logic [47:0]              r1;
    logic                     ge;
    logic [RW-1:0]            rem_sub, rem_step;
    logic [TW-1:0]            quo_step;
    logic [TW:0]              qmag;
    logic signed [TW-1:0]     q_pos, q_neg;
    logic                     div_last;
    logic signed [PW:0]       s0, s1, r0_rnd, r1_rnd;

    assign wr_en = psel && penable && pwrite;
    assign idx   = paddr[ADDR_BITS-1:2];

    always_comb begin
        unique case (idx)
            REG_MODE:    prdata = {{(DATA_BITS-3){1'b0}}, mode_reg};
            REG_PARAM_A: prdata = {{(DATA_BITS-24){1'b0}}, pa_reg};
            REG_PARAM_B: prdata = {{(DATA_BITS-24){1'b0}}, pb_reg};
            REG_PARAM_C: prdata = {{(DATA_BITS-24){1'b0}}, pc_reg};
            REG_PARAM_D: prdata = {{(DATA_BITS-24){1'b0}}, pd_reg};
            REG_ANGLE:   prdata = {{(DATA_BITS-18){1'b0}}, angle_reg};
            default:     prdata = '0;
        endcase
    end

    // A write while a rebuild is running leaves the start pending, so the
    // rebuild is run again from the newest register values.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= '0;
            pa_reg    <= '0;
            pb_reg    <= '0;
            pc_reg    <= '0;
            pd_reg    <= '0;
            angle_reg <= '0;
            start_reg <= 1'b0;
        end else begin
            if (wr_en && (idx < 3'(REG_COUNT))) begin
                start_reg <= 1'b1;
            end else if (state_reg == ST_IDLE) begin
                start_reg <= 1'b0;
            end
            if (wr_en) begin
                unique case (idx)
                    REG_MODE:    mode_reg  <= pwdata[2:0];
                    REG_PARAM_A: pa_reg    <= pwdata[23:0];
                    REG_PARAM_B: pb_reg    <= pwdata[23:0];
                    REG_PARAM_C: pc_reg    <= pwdata[23:0];
                    REG_PARAM_D: pd_reg    <= pwdata[23:0];
                    REG_ANGLE:   angle_reg <= pwdata[17:0];
                    default:     ;
                endcase
            end
        end
    end

    // Operand preparation.
    always_comb begin
        one_c  = CW'(1) <<< FRAC_BITS;
        a_full = CW'(pa_reg) <<< (FRAC_BITS - 8);
        b_full = CW'(pb_reg) <<< (FRAC_BITS - 8);

        coeff_init[0] = one_c;
        coeff_init[1] = '0;
        coeff_init[2] = '0;
        coeff_init[3] = one_c;
        off_init[0]   = '0;
        off_init[1]   = '0;
        case (mode_reg)
            MODE_TRANSLATE: begin
                off_init[0] = OW'(a_full);
                off_init[1] = OW'(b_full);
            end
            MODE_SCALE: begin
                coeff_init[0] = a_full;
                coeff_init[3] = b_full;
            end
            MODE_SHEAR: begin
                coeff_init[1] = a_full;
                coeff_init[2] = b_full;
            end
            default: ;
        endcase

        z8_0 = 19'(angle_reg);
        if (z8_0 > 19'sd46080) begin
            z8_1 = z8_0 - 19'sd92160;
        end else if (z8_0 <= -19'sd46080) begin
            z8_1 = z8_0 + 19'sd92160;
        end else begin
            z8_1 = z8_0;
        end
        flip_d = 1'b0;
        if (z8_1 > 19'sd23040) begin
            z8_2   = z8_1 - 19'sd46080;
            flip_d = 1'b1;
        end else if (z8_1 < -19'sd23040) begin
            z8_2   = z8_1 + 19'sd46080;
            flip_d = 1'b1;
        end else begin
            z8_2 = z8_1;
        end
        z16 = ZW'(z8_2) <<< 8;

        dx  = 25'(pc_reg) - 25'(pa_reg);
        dy  = 25'(pd_reg) - 25'(pb_reg);
        adx = dx[24] ? 25'(-dx) : 25'(dx);
        ady = dy[24] ? 25'(-dy) : 25'(dy);
    end

    // CORDIC step and final rounding.
    always_comb begin
        shx         = cx_reg >>> iter_reg;
        shy         = cy_reg >>> iter_reg;
        atan_s      = signed'(ZW'(ATAN_DEG_Q16[iter_reg]));
        cordic_last = (iter_reg == ITER_BITS'(CORDIC_STEPS - 1));
        one_x       = XW'(1) <<< FRAC_BITS;
        xr = (cx_reg + (XW'(1) <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
        yr = (cy_reg + (XW'(1) <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
        xc = (xr > one_x) ? one_x : ((xr < -one_x) ? -one_x : xr);
        yc = (yr > one_x) ? one_x : ((yr < -one_x) ? -one_x : yr);
        c_val = flip_reg ? TW'(-xc) : TW'(xc);
        s_val = flip_reg ? TW'(-yc) : TW'(yc);
    end

    // Restoring division step and rounding of the offset sums.
    always_comb begin
        nsum     = 50'(ux2_reg) + 50'(uy2_reg);
        r1       = neg1_reg ? (uy2_reg - ux2_reg) : (ux2_reg - uy2_reg);
        ge       = rem_reg >= RW'(n_reg);
        rem_sub  = ge ? (rem_reg - RW'(n_reg)) : rem_reg;
        rem_step = rem_sub << 1;
        quo_step = {quo_reg[TW-2:0], ge};
        qmag     = ({1'b0, quo_step} + (TW+1)'(1)) >> 1;
        q_pos    = signed'(qmag[TW-1:0]);
        q_neg    = -q_pos;
        div_last = (dcnt_reg == DCW'(DIV_STEPS - 1));
        s0       = (PW+1)'(prod_reg[0]) + (PW+1)'(prod_reg[1]);
        s1       = (PW+1)'(prod_reg[2]) + (PW+1)'(prod_reg[3]);
        r0_rnd   = (s0 + (PW+1)'(128)) >>> 8;
        r1_rnd   = (s1 + (PW+1)'(128)) >>> 8;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start_reg) begin
                    if (mode_reg == MODE_ROTATE || mode_reg == MODE_PIVOT) begin
                        state_next = ST_CORDIC;
                    end else if (mode_reg == MODE_REFLECT) begin
                        state_next = ST_SQUARE;
                    end
                end
            end
            ST_CORDIC:   if (cordic_last) state_next = ST_TRIG_FIN;
            ST_TRIG_FIN: state_next = (mode_reg == MODE_PIVOT) ? ST_OFF_MUL : ST_IDLE;
            ST_SQUARE:   state_next = ST_NORM;
            ST_NORM:     state_next = (nsum == '0) ? ST_IDLE : ST_DIVIDE;
            ST_DIVIDE:   if (div_last && phase_reg) state_next = ST_OFF_MUL;
            ST_OFF_MUL:  state_next = ST_OFF_SUM;
            ST_OFF_SUM:  state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        busy = start_reg || (state_reg != ST_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            coeff_reg[0] <= CW'(1) <<< FRAC_BITS;
            coeff_reg[1] <= '0;
            coeff_reg[2] <= '0;
            coeff_reg[3] <= CW'(1) <<< FRAC_BITS;
            off_reg[0]   <= '0;
            off_reg[1]   <= '0;
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE: begin
                    if (start_reg) begin
                        coeff_reg <= coeff_init;
                        off_reg   <= off_init;
                        z_reg     <= z16;
                        cx_reg    <= XW'(CORDIC_GAIN);
                        cy_reg    <= '0;
                        flip_reg  <= flip_d;
                        iter_reg  <= '0;
                        ux_reg    <= adx[23:0];
                        uy_reg    <= ady[23:0];
                        neg2_reg  <= dx[24] ^ dy[24];
                    end
                end
                ST_CORDIC: begin
                    if (z_reg >= 0) begin
                        cx_reg <= cx_reg - shy;
                        cy_reg <= cy_reg + shx;
                        z_reg  <= z_reg - atan_s;
                    end else begin
                        cx_reg <= cx_reg + shy;
                        cy_reg <= cy_reg - shx;
                        z_reg  <= z_reg + atan_s;
                    end
                    iter_reg <= iter_reg + ITER_BITS'(1);
                end
                ST_TRIG_FIN: begin
                    coeff_reg[0] <= CW'(c_val);
                    coeff_reg[1] <= CW'(-s_val);
                    coeff_reg[2] <= CW'(s_val);
                    coeff_reg[3] <= CW'(c_val);
                end
                ST_SQUARE: begin
                    ux2_reg  <= ux_reg * ux_reg;
                    uy2_reg  <= uy_reg * uy_reg;
                    uxy_reg  <= ux_reg * uy_reg;
                    neg1_reg <= ux_reg < uy_reg;
                end
                ST_NORM: begin
                    n_reg     <= nsum;
                    rem_reg   <= RW'(r1);
                    quo_reg   <= '0;
                    dcnt_reg  <= '0;
                    phase_reg <= 1'b0;
                end
                ST_DIVIDE: begin
                    if (div_last && !phase_reg) begin
                        coeff_reg[0] <= CW'(neg1_reg ? q_neg : q_pos);
                        coeff_reg[3] <= CW'(neg1_reg ? q_pos : q_neg);
                        rem_reg      <= RW'({uxy_reg, 1'b0});
                        quo_reg      <= '0;
                        dcnt_reg     <= '0;
                        phase_reg    <= 1'b1;
                    end else begin
                        rem_reg  <= rem_step;
                        quo_reg  <= quo_step;
                        dcnt_reg <= dcnt_reg + DCW'(1);
                        if (div_last) begin
                            coeff_reg[1] <= CW'(neg2_reg ? q_neg : q_pos);
                            coeff_reg[2] <= CW'(neg2_reg ? q_neg : q_pos);
                        end
                    end
                end
                ST_OFF_MUL: begin
                    prod_reg[0] <= PW'(signed'(coeff_reg[0][TW-1:0])) * PW'(pa_reg);
                    prod_reg[1] <= PW'(signed'(coeff_reg[1][TW-1:0])) * PW'(pb_reg);
                    prod_reg[2] <= PW'(signed'(coeff_reg[2][TW-1:0])) * PW'(pa_reg);
                    prod_reg[3] <= PW'(signed'(coeff_reg[3][TW-1:0])) * PW'(pb_reg);
                end
                ST_OFF_SUM: begin
                    off_reg[0] <= OW'((PW+1)'(a_full) - r0_rnd);
                    off_reg[1] <= OW'((PW+1)'(b_full) - r1_rnd);
                end
                default: ;
            endcase
        end
    end

    assign coeff  = coeff_reg;
    assign offset = off_reg;

endmodule

// File: rtl/aff2d_datapath.sv
// ----------------------------------------------------------------------------
// aff2d_datapath
// Four-stage multiply-add pipeline: input, products, sums, saturated output.
// ----------------------------------------------------------------------------
module aff2d_datapath
    import aff2d_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int CW        = FRAC_BITS + 16,
    parameter int OW        = FRAC_BITS + 18
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic signed [CW-1:0] coeff [4],
    input  logic signed [OW-1:0] offset [2],
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_beat_t             in_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_beat_t            m_data
);

    localparam int PW = CW + COORD_BITS;
    localparam int SW = PW + 2;
    localparam int EW = (SW > OUT_BITS + 1) ? SW : OUT_BITS + 1;
    localparam logic signed [EW-1:0] OUT_MAX =
        {{(EW-OUT_BITS+1){1'b0}}, {(OUT_BITS-1){1'b1}}};
    localparam logic signed [EW-1:0] OUT_MIN =
        {{(EW-OUT_BITS+1){1'b1}}, {(OUT_BITS-1){1'b0}}};

    logic                         v1_reg, v2_reg, v3_reg, v4_reg;
    logic                         rdy1, rdy2, rdy3, rdy4;
    logic signed [COORD_BITS-1:0] x1_reg, y1_reg;
    logic signed [PW-1:0]         p_reg [4];
    logic signed [PW-1:0]         p_next [4];
    logic signed [EW-1:0]         sum_reg [2];
    logic signed [EW-1:0]         sum_next [2];
    out_beat_t                    out_reg, out_next;

    function automatic logic signed [OUT_BITS-1:0] sat48(input logic signed [EW-1:0] v);
        if (v > OUT_MAX) begin
            return OUT_MAX[OUT_BITS-1:0];
        end else if (v < OUT_MIN) begin
            return OUT_MIN[OUT_BITS-1:0];
        end
        return v[OUT_BITS-1:0];
    endfunction

    assign rdy4     = !v4_reg || m_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_comb begin
        p_next[0] = PW'(coeff[0]) * PW'(x1_reg);
        p_next[1] = PW'(coeff[1]) * PW'(y1_reg);
        p_next[2] = PW'(coeff[2]) * PW'(x1_reg);
        p_next[3] = PW'(coeff[3]) * PW'(y1_reg);
        sum_next[0] = EW'(p_reg[0]) + EW'(p_reg[1]) + EW'(offset[0]);
        sum_next[1] = EW'(p_reg[2]) + EW'(p_reg[3]) + EW'(offset[1]);
        out_next.x_out = sat48(sum_reg[0]);
        out_next.y_out = sat48(sum_reg[1]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            x1_reg <= in_data.x_in;
            y1_reg <= in_data.y_in;
        end
        if (rdy2) p_reg <= p_next;
        if (rdy3) sum_reg <= sum_next;
        if (rdy4) out_reg <= out_next;
    end

    assign m_valid = v4_reg;
    assign m_data  = out_reg;

endmodule

// File: rtl/affine_2d_point_transform_unit.sv
// ----------------------------------------------------------------------------
// affine_2d_point_transform_unit
// Maps integer vertices through a 2x2 matrix and offset in signed fixed point.
// ----------------------------------------------------------------------------
// Each vertex beat passes a four-stage multiply-add pipeline; one beat is
// accepted per cycle while m_ready does not stall the output and no rebuild
// is running. After every register write the coefficients are rebuilt and
// s_ready stays low for that time: translate, scale and shear load their
// coefficients directly, rotation runs 16 CORDIC iterations, pivot rotation
// adds the offset multiply-add, and reflection runs two restoring divisions,
// one quotient bit per cycle, then the offset multiply-add. A write that lands
// during a rebuild makes the rebuild run once more after the current one ends.
module affine_2d_point_transform_unit
    import aff2d_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_beat_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_beat_t            m_data
);

    localparam int CW = FRAC_BITS + 16;
    localparam int OW = FRAC_BITS + 18;

    logic                 busy;
    logic                 dp_ready;
    logic signed [CW-1:0] coeff [4];
    logic signed [OW-1:0] offset [2];

    assign pready  = 1'b1;
    assign s_ready = dp_ready && !busy;

    aff2d_setup #(
        .FRAC_BITS (FRAC_BITS),
        .CW        (CW),
        .OW        (OW)
    ) u_setup (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .busy    (busy),
        .coeff   (coeff),
        .offset  (offset)
    );

    aff2d_datapath #(
        .FRAC_BITS (FRAC_BITS),
        .CW        (CW),
        .OW        (OW)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .coeff    (coeff),
        .offset   (offset),
        .in_valid (s_valid && !busy),
        .in_ready (dp_ready),
        .in_data  (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 2D affine point transform unit. Configuration
// registers are written over APB between phases that cover every mode with
// extreme and random settings. Vertex beats are checked field by field
// against a bench-side predictor of the matrix and offset setup.
// ----------------------------------------------------------------------------
module tb_top;
    import aff2d_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = 16;
    localparam longint ONE = 64'sd1 <<< FB;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        bit                 has_exp;
        longint             ex;
        longint             ey;
    } vec_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_BITS-1:0] paddr = '0;
    logic [DATA_BITS-1:0] pwdata = '0;
    logic [DATA_BITS-1:0] prdata;
    logic pready;
    logic s_valid = 1'b0;
    logic s_ready;
    in_beat_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_beat_t m_data;

    affine_2d_point_transform_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    longint cfg_reg [REG_COUNT];
    longint coef [4];
    longint offs [2];
    out_beat_t expected_points [$];
    int errors = 0;
    int idle_cycles = 0;
    int stall_left = 0;
    bit calm = 1'b0;
    bit done = 1'b0;
    logic [ADDR_BITS-1:0] addr_list [REG_COUNT];

    function automatic longint sx(longint v, int w);
        longint m;
        m = (64'sd1 <<< w) - 1;
        v = v & m;
        if (v[w-1]) return v - (64'sd1 <<< w);
        return v;
    endfunction

    function automatic longint rnd_shr(longint v, int n);
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    task automatic cordic_trig(output longint c, output longint s);
        longint z, x, y, nx;
        bit flip;
        z = sx(cfg_reg[REG_ANGLE], 18) * 256;
        x = 652032874; y = 0; flip = 0;
        while (z > 180 * 65536) z -= 360 * 65536;
        while (z <= -180 * 65536) z += 360 * 65536;
        if (z > 90 * 65536) begin
            z -= 180 * 65536; flip = 1;
        end else if (z < -90 * 65536) begin
            z += 180 * 65536; flip = 1;
        end
        for (int i = 0; i < 16; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i); y = y + (x >>> i); z -= longint'(ATAN_DEG_Q16[i]);
            end else begin
                nx = x + (y >>> i); y = y - (x >>> i); z += longint'(ATAN_DEG_Q16[i]);
            end
            x = nx;
        end
        x = rnd_shr(x, 30 - FB);
        y = rnd_shr(y, 30 - FB);
        if (x > ONE) x = ONE;
        if (x < -ONE) x = -ONE;
        if (y > ONE) y = ONE;
        if (y < -ONE) y = -ONE;
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    function automatic longint frac_quot(longint unsigned r, longint unsigned n);
        longint unsigned q;
        q = 0;
        for (int i = 0; i <= FB + 1; i++) begin
            q <<= 1;
            if (r >= n) begin
                q |= 1; r -= n;
            end
            r <<= 1;
        end
        return longint'((q + 1) >> 1);
    endfunction

    task automatic rebuild_coeffs();
        longint a8, b8, c8, d8, av, bv, c, s, dx, dy, q1, q2;
        longint unsigned ux, uy, n;
        a8 = sx(cfg_reg[REG_PARAM_A], 24); b8 = sx(cfg_reg[REG_PARAM_B], 24);
        c8 = sx(cfg_reg[REG_PARAM_C], 24); d8 = sx(cfg_reg[REG_PARAM_D], 24);
        av = a8 * (1 << (FB - 8)); bv = b8 * (1 << (FB - 8));
        coef[0] = ONE; coef[1] = 0; coef[2] = 0; coef[3] = ONE;
        offs[0] = 0; offs[1] = 0;
        case (cfg_reg[REG_MODE][2:0]) inside
            MODE_TRANSLATE: begin
                offs[0] = av; offs[1] = bv;
            end
            MODE_SCALE: begin
                coef[0] = av; coef[3] = bv;
            end
            MODE_ROTATE, MODE_PIVOT: begin
                cordic_trig(c, s);
                coef[0] = c; coef[1] = -s; coef[2] = s; coef[3] = c;
                if (cfg_reg[REG_MODE][2:0] == MODE_PIVOT) begin
                    offs[0] = av - rnd_shr(c * a8 - s * b8, 8);
                    offs[1] = bv - rnd_shr(s * a8 + c * b8, 8);
                end
            end
            MODE_SHEAR: begin
                coef[1] = av; coef[2] = bv;
            end
            MODE_REFLECT: begin
                dx = c8 - a8; dy = d8 - b8;
                ux = dx < 0 ? -dx : dx;
                uy = dy < 0 ? -dy : dy;
                n = ux * ux + uy * uy;
                if (n != 0) begin
                    if (ux >= uy) q1 = frac_quot(ux * ux - uy * uy, n);
                    else q1 = -frac_quot(uy * uy - ux * ux, n);
                    q2 = frac_quot(2 * ux * uy, n);
                    if ((dx < 0) != (dy < 0)) q2 = -q2;
                    coef[0] = q1; coef[1] = q2; coef[2] = q2; coef[3] = -q1;
                    offs[0] = av - rnd_shr(q1 * a8 + q2 * b8, 8);
                    offs[1] = bv - rnd_shr(q2 * a8 - q1 * b8, 8);
                end
            end
            default: ;
        endcase
    endtask

    function automatic logic [47:0] clamp48(longint v);
        if (v > (64'sd1 <<< 47) - 1) v = (64'sd1 <<< 47) - 1;
        if (v < -(64'sd1 <<< 47)) v = -(64'sd1 <<< 47);
        return v[47:0];
    endfunction

    function automatic out_beat_t transform_point(logic signed [15:0] x,
                                                 logic signed [15:0] y);
        out_beat_t r;
        longint xl, yl;
        xl = x; yl = y;
        r.x_out = clamp48(coef[0] * xl + coef[1] * yl + offs[0]);
        r.y_out = clamp48(coef[2] * xl + coef[3] * yl + offs[1]);
        return r;
    endfunction

    task automatic write_reg(int idx, longint value);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= addr_list[idx]; pwdata <= value[31:0];
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        cfg_reg[idx] = value & ((64'sd1 <<< (idx == REG_MODE ? 3 :
                                 idx == REG_ANGLE ? 18 : 24)) - 1);
        rebuild_coeffs();
    endtask

    task automatic drain_points();
        s_valid <= 1'b0;
        while (expected_points.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic random_idle();
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
    endtask

    task automatic push_point(vec_row_t row);
        out_beat_t e;
        random_idle();
        s_data.x_in <= row.x;
        s_data.y_in <= row.y;
        s_valid <= 1'b1;
        e = transform_point(row.x, row.y);
        if (row.has_exp) begin
            e.x_out = clamp48(row.ex);
            e.y_out = clamp48(row.ey);
        end
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_points = {expected_points, e};
    endtask

    task automatic random_config(int mode);
        write_reg(REG_MODE, mode);
        for (int i = 1; i <= 4; i++) begin
            case ($urandom_range(0, 3))
                0: write_reg(i, 24'h7fffff);
                1: write_reg(i, 24'h800000);
                2: write_reg(i, $urandom_range(0, 4095) - 2048);
                default: write_reg(i, $urandom);
            endcase
        end
        case ($urandom_range(0, 3))
            0: write_reg(REG_ANGLE, 92160);
            1: write_reg(REG_ANGLE, -92160);
            default: write_reg(REG_ANGLE, longint'($urandom_range(0, 184320)) - 92160);
        endcase
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (stall_left > 0 && !calm) begin
                stall_left <= stall_left - 1;
                m_ready <= 1'b0;
            end else if ($urandom_range(0, 7) == 0 && !calm) begin
                stall_left <= $urandom_range(0, 13);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        out_beat_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_points.size() == 0) begin
                $error("unexpected beat x_out=%0h y_out=%0h", m_data.x_out, m_data.y_out);
                errors++;
            end else begin
                e = expected_points.pop_front();
                if (m_data.x_out !== e.x_out) begin
                    $error("x_out expected %0h actual %0h", e.x_out, m_data.x_out);
                    errors++;
                end
                if (m_data.y_out !== e.y_out) begin
                    $error("y_out expected %0h actual %0h", e.y_out, m_data.y_out);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    vec_row_t dir_rows [$];

    initial begin
        vec_row_t r;
        int mode;
        for (int i = 0; i < REG_COUNT; i++) begin
            addr_list[i] = ADDR_BITS'(4 * i);
            cfg_reg[i] = 0;
        end
        rebuild_coeffs();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        dir_rows = '{
            '{16'sh7fff, 16'sh7fff, 1, 32767 * ONE, 32767 * ONE},
            '{16'sh8000, 16'sh8000, 1, -32768 * ONE, -32768 * ONE},
            '{16'sh7fff, 16'sh8000, 1, 32767 * ONE, -32768 * ONE},
            '{16'sh0000, 16'sh0000, 1, 0, 0},
            '{16'shffff, 16'sh0001, 1, -ONE, ONE},
            '{16'sh5555, 16'shaaaa, 0, 0, 0}
        };
        foreach (dir_rows[i]) push_point(dir_rows[i]);
        drain_points();
        for (int m = 0; m < 8; m++) begin
            write_reg(REG_MODE, m);
            for (int i = 1; i <= 4; i++) write_reg(i, (m & 1) ? 24'h7fffff : 24'h800000);
            write_reg(REG_ANGLE, (m & 2) ? 92160 : -92160);
            foreach (dir_rows[i]) begin
                r = dir_rows[i]; r.has_exp = 0;
                push_point(r);
            end
            drain_points();
        end
        write_reg(REG_MODE, MODE_REFLECT);
        write_reg(REG_PARAM_A, 256); write_reg(REG_PARAM_B, 512);
        write_reg(REG_PARAM_C, 256); write_reg(REG_PARAM_D, 512);
        push_point(dir_rows[5]);
        drain_points();
        for (int ph = 0; ph < 46; ph++) begin
            mode = (ph < 40) ? ph % 6 : $urandom_range(0, 7);
            random_config(mode);
            if (mode == MODE_REFLECT && $urandom_range(0, 3) == 0) begin
                write_reg(REG_PARAM_C, cfg_reg[REG_PARAM_A]);
                write_reg(REG_PARAM_D, cfg_reg[REG_PARAM_B]);
            end
            if (ph >= 42) calm = 1'b1;
            for (int k = 0; k < 25; k++) begin
                r.x = $urandom; r.y = $urandom; r.has_exp = 0;
                if ($urandom_range(0, 3) == 0) begin
                    r.x = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
                    r.y = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
                end
                push_point(r);
            end
            drain_points();
        end
        done = 1'b1;
        if (errors == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end
endmodule
